>>> rtl/mp2_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp2_pkg
// Shared constants and types for the 2x2 stride-2 max pooling block.
// ----------------------------------------------------------------------------
package mp2_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int DATA_BITS  = 16;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int ADDR_BITS  = $clog2(LINE_DEPTH);
    localparam int COL_BITS   = $clog2(MAX_WIDTH);

    localparam int WIDTH_BITS   = 9;
    localparam int HEIGHT_BITS  = 16;
    localparam int CHAN_BITS    = 16;
    localparam int CFG_BITS     = 16;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 2'd2;

    typedef logic signed [DATA_BITS-1:0] pixel_t;

    // one cycle's access to the line store
    typedef struct packed {
        logic                 wr_en;
        logic [ADDR_BITS-1:0] wr_addr;
        pixel_t               wr_data;
        logic                 rd_en;
        logic [ADDR_BITS-1:0] rd_addr;
    } line_req_t;

endpackage : mp2_pkg
`default_nettype wire

>>> rtl/max_pool_2x2_stride2.sv
`default_nettype none
// ----------------------------------------------------------------------------
// max_pool_2x2_stride2
// Streaming 2x2 max pooling, stride 2, over a channel-major image.
// ----------------------------------------------------------------------------
// Pixels come in on the s_axis channel one word at a time in channel, row,
// column order; pooled words leave on m_axis, tlast set on the final window
// of the final channel. The user sets geometry through the cfg write port
// (width, height, channel count) while the block is idle; it is not enforced.
// Even rows write the maximum of each column pair into the line store; odd
// rows read it back and emit the window maximum. The store read is issued on
// the left pixel of a pair and its data used with the right pixel.
// Throughput: one pixel per cycle while m_axis does not stall. A window's word
// is registered in the compare stage, then in the output register, after its
// last pixel is taken, and is then valid on m_axis.
// When the receiver stalls the output register and the compare stage fill,
// then s_axis_tready drops; nothing is lost.
// Reset clears positions and the configuration (2x2, one channel). The line
// store is not cleared: every entry is written on an even row before the
// following odd row reads it.
// ----------------------------------------------------------------------------
module max_pool_2x2_stride2
    import mp2_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [DATA_BITS-1:0]    s_axis_tdata,   // [15:0] pixel_value
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [DATA_BITS-1:0]         m_axis_tdata,   // [15:0] pooled_value
    output logic                         m_axis_tlast,   // final_result
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0]     cfg_data
);

    // configuration
    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [CHAN_BITS-1:0]   chans_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_BITS'(2);
            height_reg <= HEIGHT_BITS'(2);
            chans_reg  <= CHAN_BITS'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg  <= cfg_data[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT:  height_reg <= cfg_data[HEIGHT_BITS-1:0];
                REG_CHANNEL_COUNT: chans_reg  <= cfg_data[CHAN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamped geometry
    logic [WIDTH_BITS-1:0]  w_eff, out_w;
    logic [HEIGHT_BITS-1:0] h_eff, out_h;
    logic [CHAN_BITS-1:0]   c_eff;

    always_comb
    begin
        if (width_reg < WIDTH_BITS'(2))
            w_eff = WIDTH_BITS'(2);
        else if (width_reg > WIDTH_BITS'(MAX_WIDTH))
            w_eff = WIDTH_BITS'(MAX_WIDTH);
        else
            w_eff = width_reg;
        h_eff = (height_reg < HEIGHT_BITS'(2)) ? HEIGHT_BITS'(2) : height_reg;
        c_eff = (chans_reg == '0) ? CHAN_BITS'(1) : chans_reg;
        out_w = {w_eff[WIDTH_BITS-1:1], 1'b0};
        out_h = {h_eff[HEIGHT_BITS-1:1], 1'b0};
    end

    // positions
    logic [COL_BITS-1:0]    col_reg, col_next;
    logic [HEIGHT_BITS-1:0] row_reg, row_next;
    logic [CHAN_BITS-1:0]   chan_reg, chan_next;
    pixel_t                 pair_reg;

    logic                   s_fire;
    logic [COL_BITS:0]      col_inc;
    logic [HEIGHT_BITS:0]   row_inc;
    logic [CHAN_BITS:0]     chan_inc;
    pixel_t                 pix;
    pixel_t                 pair_max;
    logic                   in_window;
    logic                   is_last;

    assign pix      = pixel_t'(s_axis_tdata);
    assign col_inc  = {1'b0, col_reg} + (COL_BITS+1)'(1);
    assign row_inc  = {1'b0, row_reg} + (HEIGHT_BITS+1)'(1);
    assign chan_inc = {1'b0, chan_reg} + (CHAN_BITS+1)'(1);
    assign pair_max = (pix > pair_reg) ? pix : pair_reg;

    assign in_window = col_reg[0]
                     && ({{(WIDTH_BITS-COL_BITS){1'b0}}, col_reg} < out_w)
                     && (row_reg < out_h);
    assign is_last = (row_inc == {1'b0, out_h})
                   && ((WIDTH_BITS)'(col_inc) == out_w)
                   && (chan_inc == {1'b0, c_eff});

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        chan_next = chan_reg;
        if ((WIDTH_BITS)'(col_inc) >= w_eff)
        begin
            col_next = '0;
            if (row_inc >= {1'b0, h_eff})
            begin
                row_next = '0;
                if (chan_inc >= {1'b0, c_eff})
                    chan_next = '0;
                else
                    chan_next = chan_inc[CHAN_BITS-1:0];
            end
            else
            begin
                row_next = row_inc[HEIGHT_BITS-1:0];
            end
        end
        else
        begin
            col_next = col_inc[COL_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            chan_reg <= '0;
            pair_reg <= '0;
        end
        else if (s_fire)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            chan_reg <= chan_next;
            if (!col_reg[0])
                pair_reg <= pix;
        end
    end

    // line store: read on the left pixel, write on the right pixel of an even row
    line_req_t lreq;
    pixel_t    line_data;

    always_comb
    begin
        lreq.rd_en   = s_fire && !col_reg[0];
        lreq.rd_addr = col_reg[COL_BITS-1:1];
        lreq.wr_en   = s_fire && in_window && !row_reg[0];
        lreq.wr_addr = col_reg[COL_BITS-1:1];
        lreq.wr_data = pair_max;
    end

    mp2_line_store u_line
    (
        .clk     (clk),
        .req     (lreq),
        .rd_data (line_data)
    );

    // compare stage and output register
    logic   cmp_valid_reg;
    pixel_t cmp_max_reg;
    logic   cmp_last_reg;
    logic   out_valid_reg;
    pixel_t out_data_reg;
    logic   out_last_reg;
    logic   out_load;
    logic   cmp_move;

    assign out_load      = !out_valid_reg || m_axis_tready;
    assign cmp_move      = cmp_valid_reg && out_load;
    assign s_axis_tready = !cmp_valid_reg || out_load;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                cmp_valid_reg <= s_fire && in_window && row_reg[0];
            if (out_load)
                out_valid_reg <= cmp_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            cmp_max_reg  <= pair_max;
            cmp_last_reg <= is_last;
        end
        if (cmp_move)
        begin
            out_data_reg <= (line_data > cmp_max_reg) ? line_data : cmp_max_reg;
            out_last_reg <= cmp_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule : max_pool_2x2_stride2
`default_nettype wire

>>> rtl/mp2_line_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp2_line_store
// Line store of column-pair maxima: one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module mp2_line_store
    import mp2_pkg::*;
(
    input  wire logic      clk,
    input  wire line_req_t req,
    output pixel_t         rd_data
);

    pixel_t mem [LINE_DEPTH];
    pixel_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : mp2_line_store
`default_nettype wire

>>> test/tb_max_pool_2x2_stride2.sv
// ----------------------------------------------------------------------------
// tb_max_pool_2x2_stride2
// Self-checking bench for the streaming 2x2 stride-2 max pooling block.
// ----------------------------------------------------------------------------
// A short scripted run covers the pixel extremes, odd image geometry and
// out-of-range register values. It is followed by random phases of whole and
// partial frames under random geometry. A local pooling predictor follows
// every accepted pixel and queues the window maxima it expects. Each word
// leaving m_axis is checked against the oldest queued window. The sender
// works in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_max_pool_2x2_stride2;
    import mp2_pkg::*;

    // index 3 has no register behind it; writes to it must change nothing
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PIXEL_TARGET  = 1900;
    localparam int SCRIPT_PIXELS = 25;
    localparam int PHASE_CAP     = 600;

    typedef enum logic {STEP_PIXEL, STEP_CONFIG} row_kind_t;

    typedef struct packed {
        pixel_t value;
        logic   last;
    } window_t;

    typedef struct packed {
        logic    typed;
        window_t want;
    } glance_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_IDX_BITS-1:0] index;
        logic [CFG_BITS-1:0]     value;
        logic                    typed;
        window_t                 want;
    } script_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [DATA_BITS-1:0]    s_axis_tdata = '0;     // [15:0] pixel_value
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [DATA_BITS-1:0]    m_axis_tdata;          // [15:0] pooled_value
    logic                    m_axis_tlast;          // final_result
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]     cfg_data = '0;

    max_pool_2x2_stride2 uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // pooling predictor state
    logic [WIDTH_BITS-1:0]  width_reg = 9'd2;
    logic [HEIGHT_BITS-1:0] height_reg = 16'd2;
    logic [CHAN_BITS-1:0]   chans_reg = 16'd1;
    pixel_t                 line_max [LINE_DEPTH];
    pixel_t                 pair_max = '0;
    int                     col_pos = 0;
    int                     row_pos = 0;
    int                     chan_pos = 0;

    window_t pending_windows [$];
    glance_t glance_q [$];

    int pixels_sent = 0;
    int pixels_taken = 0;
    int windows_seen = 0;
    int cfg_writes = 0;
    int mismatches = 0;
    int burst_left = 0;

    // pixel rows: index is unused; typed rows carry a hand-read expectation
    script_row_t script [0:29] = '{
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'h7FFF, 1'b0, '{16'sh0000, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'h8000, 1'b0, '{16'sh0000, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'h8000, 1'b0, '{16'sh0000, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'h8000, 1'b1, '{16'sh7FFF, 1'b1}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'h8000, 1'b0, '{16'sh0000, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'h8000, 1'b0, '{16'sh0000, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'h8000, 1'b0, '{16'sh0000, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'h8000, 1'b1, '{16'sh8000, 1'b1}},
        // 3x3: odd last column and odd last row are dropped
        '{STEP_CONFIG, REG_IMAGE_WIDTH,   16'd3,    1'b0, '{16'sh0000, 1'b0}},
        '{STEP_CONFIG, REG_IMAGE_HEIGHT,  16'd3,    1'b0, '{16'sh0000, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'h0001, 1'b0, '{16'sh0000, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'h0002, 1'b0, '{16'sh0000, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'h0064, 1'b0, '{16'sh0000, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'h0003, 1'b0, '{16'sh0000, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'h0004, 1'b1, '{16'sh0004, 1'b1}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'hFFFB, 1'b0, '{16'sh0000, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'h00C8, 1'b0, '{16'sh0000, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'h00C8, 1'b0, '{16'sh0000, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'h00C8, 1'b0, '{16'sh0000, 1'b0}},
        // width 0 and height 1 act as 2, two channels
        '{STEP_CONFIG, REG_IMAGE_WIDTH,   16'd0,    1'b0, '{16'sh0000, 1'b0}},
        '{STEP_CONFIG, REG_IMAGE_HEIGHT,  16'd1,    1'b0, '{16'sh0000, 1'b0}},
        '{STEP_CONFIG, REG_CHANNEL_COUNT, 16'd2,    1'b0, '{16'sh0000, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'hFFFF, 1'b0, '{16'sh0000, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'hFFFF, 1'b0, '{16'sh0000, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'hFFFF, 1'b0, '{16'sh0000, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'hFFFF, 1'b1, '{16'shFFFF, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'h0009, 1'b0, '{16'sh0000, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'hFFF7, 1'b0, '{16'sh0000, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'h0000, 1'b0, '{16'sh0000, 1'b0}},
        '{STEP_PIXEL,  REG_IMAGE_WIDTH,   16'h0001, 1'b0, '{16'sh0000, 1'b0}}
    };

    function automatic int eff_width();
        if (width_reg < 2) return 2;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int eff_height();
        return (height_reg < 2) ? 2 : int'(height_reg);
    endfunction

    function automatic int eff_channels();
        return (chans_reg == 0) ? 1 : int'(chans_reg);
    endfunction

    // advance the pooling state by one pixel; returns 1 when a window closes
    function automatic bit take_pixel(input pixel_t px, output window_t win);
        int     w;
        int     out_w;
        int     out_h;
        int     slot;
        pixel_t m;
        bit     hit;
        w     = eff_width();
        out_w = w & ~1;
        out_h = eff_height() & ~1;
        hit   = 1'b0;
        win   = '0;
        if (col_pos % 2 == 0)
        begin
            pair_max = px;
        end
        else if (col_pos < out_w && row_pos < out_h)
        begin
            m    = (px > pair_max) ? px : pair_max;
            slot = col_pos >> 1;
            if (row_pos % 2 == 0)
            begin
                line_max[slot] = m;
            end
            else
            begin
                win.value = (line_max[slot] > m) ? line_max[slot] : m;
                win.last  = (row_pos + 1 == out_h) && (col_pos + 1 == out_w) &&
                            (chan_pos + 1 == eff_channels());
                hit = 1'b1;
            end
        end
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= eff_height())
            begin
                row_pos = 0;
                chan_pos++;
                if (chan_pos >= eff_channels())
                    chan_pos = 0;
            end
        end
        return hit;
    endfunction

    always @(posedge clk)
    begin : scoreboard
        window_t calc;
        window_t want;
        window_t got;
        glance_t g;
        bit      hit;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:   width_reg  = cfg_data[WIDTH_BITS-1:0];
                    REG_IMAGE_HEIGHT:  height_reg = cfg_data[HEIGHT_BITS-1:0];
                    REG_CHANNEL_COUNT: chans_reg  = cfg_data[CHAN_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                hit = take_pixel(pixel_t'(s_axis_tdata), calc);
                pixels_taken++;
                if (glance_q.size() != 0)
                begin
                    g = glance_q.pop_front();
                    if (g.typed)
                    begin
                        calc = g.want;
                        hit  = 1'b1;
                    end
                end
                if (hit)
                    pending_windows.push_back(calc);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.value = m_axis_tdata;
                got.last  = m_axis_tlast;
                windows_seen++;
                if (pending_windows.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected word %h last %b", $time, got.value,
                                 got.last);
                end
                else
                begin
                    want = pending_windows.pop_front();
                    if (want !== got)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: window max exp %h last %b, got %h last %b",
                                     $time, want.value, want.last, got.value, got.last);
                    end
                end
            end
        end
    end

    // receiver: the stall pattern switches to a random mode after each random-length run
    int stall_mode = 0;
    int stall_left = 0;
    int stall_tick = 0;

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 300);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= (stall_tick % 4 == 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic logic [DATA_BITS-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 3)) - 16'd2;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_pixel(input logic [DATA_BITS-1:0] px);
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        burst_left--;
        pixels_sent++;
    endtask

    // hold the stream until every queued window is out and the pipe is empty
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_windows.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cfg_writes++;
    endtask

    // run on to the start of a channel so the width may change safely;
    // a huge height is first cut down to end the channel soon
    task automatic finish_channel();
        int w;
        int left;
        wait_idle();
        if (row_pos == 0 && col_pos == 0)
            return;
        w = eff_width();
        if (row_pos + 1 < eff_height() && (eff_height() - row_pos - 1) * w > PHASE_CAP)
            cfg_write(REG_IMAGE_HEIGHT, 16'((row_pos + 1 < 2) ? 2 : row_pos + 1));
        if (row_pos >= eff_height())
            left = w - col_pos;
        else
            left = (eff_height() - row_pos - 1) * w + w - col_pos;
        repeat (left) push_pixel(random_pixel());
        wait_idle();
    endtask

    initial
    begin
        #6_000_000;
        $display("tb_max_pool_2x2_stride2: errors");
        $finish;
    end

    initial
    begin
        int    sel;
        int    n;
        longint frame;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == STEP_CONFIG)
            begin
                wait_idle();
                cfg_write(script[i].index, script[i].value);
            end
            else
            begin
                glance_q.push_back('{script[i].typed, script[i].want});
                push_pixel(script[i].value);
            end
        end

        while (pixels_sent < SCRIPT_PIXELS + PIXEL_TARGET)
        begin
            wait_idle();
            sel = $urandom_range(0, 11);
            if (sel == 0)
            begin
                // largest geometry; frames larger than the phase cap are only part-fed
                finish_channel();
                case ($urandom_range(0, 2))
                    0:       cfg_write(REG_IMAGE_WIDTH, 16'd511);
                    1:       cfg_write(REG_IMAGE_WIDTH, 16'd256);
                    default: cfg_write(REG_IMAGE_WIDTH, 16'd257);
                endcase
                cfg_write(REG_IMAGE_HEIGHT, $urandom_range(0, 1) ? 16'hFFFF : 16'd2);
                cfg_write(REG_CHANNEL_COUNT, $urandom_range(0, 1) ? 16'hFFFF : 16'd1);
            end
            else if (sel == 1)
            begin
                // below-range values; upper width bits are ignored
                finish_channel();
                cfg_write(REG_IMAGE_WIDTH,
                          16'($urandom_range(0, 127) << WIDTH_BITS) |
                          16'($urandom_range(0, 1)));
                cfg_write(REG_IMAGE_HEIGHT, 16'($urandom_range(0, 1)));
                cfg_write(REG_CHANNEL_COUNT, 16'd0);
            end
            else if (sel == 2)
            begin
                cfg_write(REG_SPARE, 16'($urandom));
            end
            else if (sel <= 4)
            begin
                // may land mid-frame: positions keep counting
                cfg_write(REG_IMAGE_HEIGHT, 16'($urandom_range(2, 7)));
                cfg_write(REG_CHANNEL_COUNT, 16'($urandom_range(1, 3)));
            end
            else if (sel <= 9)
            begin
                finish_channel();
                cfg_write(REG_IMAGE_WIDTH, 16'($urandom_range(2, 12)));
                cfg_write(REG_IMAGE_HEIGHT, 16'($urandom_range(2, 7)));
                cfg_write(REG_CHANNEL_COUNT, 16'($urandom_range(1, 3)));
            end

            frame = longint'(eff_width()) * eff_height() * eff_channels();
            if (frame > PHASE_CAP)
            begin
                n = $urandom_range(300, PHASE_CAP);
            end
            else
            begin
                n = $urandom_range(1, 3) * int'(frame);
                if ($urandom_range(0, 3) == 0)
                    n = $urandom_range(1, int'(frame));
            end
            // keep the total near the target
            if (n > SCRIPT_PIXELS + PIXEL_TARGET - pixels_sent)
                n = SCRIPT_PIXELS + PIXEL_TARGET - pixels_sent;
            repeat (n) push_pixel(random_pixel());
        end

        wait_idle();
        $display("pooled %0d pixels into %0d checked words across %0d register writes",
                 pixels_taken, windows_seen, cfg_writes);
        $display("mismatching words: %0d", mismatches);
        if (mismatches == 0)
            $display("tb_max_pool_2x2_stride2: clean");
        else
            $display("tb_max_pool_2x2_stride2: errors");
        $finish;
    end

endmodule

>>> max_pool_2x2_stride2.f
rtl/mp2_pkg.sv
rtl/mp2_line_store.sv
rtl/max_pool_2x2_stride2.sv
test/tb_max_pool_2x2_stride2.sv
